[rtl/gpio_eic_pkg.sv]
package gpio_eic_pkg;

  localparam int PIN_COUNT = 16;
  localparam int PIN_W     = 16;
  localparam int EDGE_W    = 2 * PIN_W;
  localparam int DATA_W    = 32;

  localparam logic [PIN_W-1:0] PIN_MASK =
    (PIN_COUNT >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((32'd1 << PIN_COUNT) - 32'd1);

  localparam logic [DATA_W-1:0] SOFT_RESET_BIT = 32'h0000_0002;

  localparam int IN_TUSER_W  = 6;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_kind_t;

  typedef enum logic [3:0] {
    REG_DIR       = 4'd0,
    REG_DATAIN    = 4'd1,
    REG_DATAOUT   = 4'd2,
    REG_SETOUT    = 4'd3,
    REG_CLROUT    = 4'd4,
    REG_EDGE1     = 4'd5,
    REG_EDGE2     = 4'd6,
    REG_STATUS    = 4'd7,
    REG_IRQEN     = 4'd8,
    REG_IRQEN_SET = 4'd9,
    REG_IRQEN_CLR = 4'd10,
    REG_WAKE      = 4'd11,
    REG_WAKE_SET  = 4'd12,
    REG_WAKE_CLR  = 4'd13,
    REG_SYSCONFIG = 4'd14,
    REG_SYSSTATUS = 4'd15
  } reg_sel_t;

  typedef struct packed {
    req_kind_t         req_type;
    reg_sel_t          reg_sel;
    logic [DATA_W-1:0] wdata;
    logic [PIN_W-1:0]  pins_in;
  } gpio_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [PIN_W-1:0]  pins_out;
    logic [PIN_W-1:0]  pins_drive;
    logic              irq;
    logic              wakeup;
  } gpio_res_t;

  function automatic logic [EDGE_W-1:0] edge_mask_f();
    logic [EDGE_W-1:0] m;
    m = '0;
    for (int i = 0; i < PIN_W; i++) begin
      if (PIN_MASK[i]) begin
        m[2*i +: 2] = 2'b11;
      end
    end
    return m;
  endfunction

  localparam logic [EDGE_W-1:0] EDGE_MASK = edge_mask_f();

endpackage

[rtl/gpio_edge_irq_controller.sv]
// Sixteen-pin GPIO block with edge interrupts, driven by one request stream: each input
// transaction is a register read, a register write or a pin sample, and each produces exactly
// one output transaction carrying read data, the pin output levels and drive enables, the irq
// line and the wakeup flag as they stand after that request. A request passes through one
// input register and one result register; its result is presented once it has moved from the
// input register into the result register. A new request can be accepted in every cycle (one
// transaction per cycle sustained) as long as results are taken; the register file is updated
// when a request moves from the input register into the result register.
module gpio_edge_irq_controller (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // wdata[31:0], pins_in[47:32]
  input  logic [gpio_eic_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // req_type[1:0], reg_sel[5:2]
  input  logic [gpio_eic_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // rdata[31:0], pins_out[47:32], pins_drive[63:48], irq[64], wakeup[65], zero[71:66]
  output logic [gpio_eic_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import gpio_eic_pkg::*;

  gpio_req_t req_q;
  logic      req_valid;
  gpio_res_t res_d;
  gpio_res_t res_q;
  logic      res_valid;
  logic      advance;

  assign advance       = !res_valid || m_axis_tready;
  assign s_axis_tready = !req_valid || advance;

  gpio_eic_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (req_valid && advance),
    .req  (req_q),
    .res  (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q.req_type <= req_kind_t'(s_axis_tuser[1:0]);
      req_q.reg_sel  <= reg_sel_t'(s_axis_tuser[5:2]);
      req_q.wdata    <= s_axis_tdata[31:0];
      req_q.pins_in  <= s_axis_tdata[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {6'b0, res_q.wakeup, res_q.irq, res_q.pins_drive,
                          res_q.pins_out, res_q.rdata};

endmodule

[rtl/gpio_eic_core.sv]
module gpio_eic_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  gpio_eic_pkg::gpio_req_t req,
  output gpio_eic_pkg::gpio_res_t res
);
  import gpio_eic_pkg::*;

  logic [PIN_W-1:0]  direction_mask, direction_mask_next;
  logic [PIN_W-1:0]  output_latch, output_latch_next;
  logic [EDGE_W-1:0] edge_control, edge_control_next;
  logic [PIN_W-1:0]  irq_status, irq_status_next;
  logic [PIN_W-1:0]  irq_enable, irq_enable_next;
  logic [PIN_W-1:0]  wake_enable, wake_enable_next;
  logic [PIN_W-1:0]  last_pins, last_pins_next;
  logic              reset_done, reset_done_next;

  logic [PIN_W-1:0]  m;
  logic [PIN_W-1:0]  p;
  logic [PIN_W-1:0]  rising;
  logic [PIN_W-1:0]  falling;
  logic [PIN_W-1:0]  edges;
  logic [DATA_W-1:0] read_val;

  assign m       = req.wdata[PIN_W-1:0] & PIN_MASK;
  assign p       = req.pins_in & PIN_MASK;
  assign rising  = p & ~last_pins;
  assign falling = last_pins & ~p;

  always_comb begin
    edges = '0;
    for (int i = 0; i < PIN_W; i++) begin
      edges[i] = (edge_control[2*i] & falling[i]) | (edge_control[2*i+1] & rising[i]);
    end
    edges = edges & PIN_MASK;
  end

  always_comb begin
    unique case (req.reg_sel)
      REG_DIR:       read_val = DATA_W'(direction_mask);
      REG_DATAIN:    read_val = DATA_W'(last_pins);
      REG_DATAOUT,
      REG_SETOUT,
      REG_CLROUT:    read_val = DATA_W'(output_latch);
      REG_EDGE1:     read_val = DATA_W'(edge_control[15:0]);
      REG_EDGE2:     read_val = DATA_W'(edge_control[31:16]);
      REG_STATUS:    read_val = DATA_W'(irq_status);
      REG_IRQEN,
      REG_IRQEN_SET,
      REG_IRQEN_CLR: read_val = DATA_W'(irq_enable);
      REG_WAKE,
      REG_WAKE_SET,
      REG_WAKE_CLR:  read_val = DATA_W'(wake_enable);
      REG_SYSCONFIG: read_val = '0;
      default:       read_val = DATA_W'(reset_done);
    endcase
  end

  always_comb begin
    direction_mask_next = direction_mask;
    output_latch_next   = output_latch;
    edge_control_next   = edge_control;
    irq_status_next     = irq_status;
    irq_enable_next     = irq_enable;
    wake_enable_next    = wake_enable;
    last_pins_next      = last_pins;
    reset_done_next     = reset_done;
    case (req.req_type)
      REQ_WRITE: begin
        unique case (req.reg_sel)
          REG_DIR:       direction_mask_next = m;
          REG_DATAOUT:   output_latch_next   = m;
          REG_SETOUT:    output_latch_next   = output_latch | m;
          REG_CLROUT:    output_latch_next   = output_latch & ~m;
          REG_EDGE1:     edge_control_next   = {edge_control[31:16], req.wdata[15:0]} & EDGE_MASK;
          REG_EDGE2:     edge_control_next   = {req.wdata[15:0], edge_control[15:0]} & EDGE_MASK;
          REG_STATUS:    irq_status_next     = irq_status & ~m;
          REG_IRQEN:     irq_enable_next     = m;
          REG_IRQEN_SET: irq_enable_next     = irq_enable | m;
          REG_IRQEN_CLR: irq_enable_next     = irq_enable & ~m;
          REG_WAKE:      wake_enable_next    = m;
          REG_WAKE_SET:  wake_enable_next    = wake_enable | m;
          REG_WAKE_CLR:  wake_enable_next    = wake_enable & ~m;
          REG_SYSCONFIG: begin
            if ((req.wdata & SOFT_RESET_BIT) != '0) begin
              direction_mask_next = PIN_MASK;
              output_latch_next   = '0;
              edge_control_next   = '0;
              irq_status_next     = '0;
              irq_enable_next     = '0;
              wake_enable_next    = '0;
              last_pins_next      = '0;
              reset_done_next     = 1'b1;
            end
          end
          default: ;
        endcase
      end
      REQ_SAMPLE: begin
        irq_status_next = irq_status | edges;
        last_pins_next  = p;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.rdata      = (req.req_type == REQ_READ) ? read_val : '0;
    res.pins_out   = output_latch_next;
    res.pins_drive = ~direction_mask_next & PIN_MASK;
    res.irq        = |(irq_status_next & irq_enable_next);
    res.wakeup     = (req.req_type == REQ_SAMPLE) && ((edges & wake_enable) != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_mask <= PIN_MASK;
      output_latch   <= '0;
      edge_control   <= '0;
      irq_status     <= '0;
      irq_enable     <= '0;
      wake_enable    <= '0;
      last_pins      <= '0;
      reset_done     <= 1'b1;
    end else if (step) begin
      direction_mask <= direction_mask_next;
      output_latch   <= output_latch_next;
      edge_control   <= edge_control_next;
      irq_status     <= irq_status_next;
      irq_enable     <= irq_enable_next;
      wake_enable    <= wake_enable_next;
      last_pins      <= last_pins_next;
      reset_done     <= reset_done_next;
    end
  end

endmodule

[rtl/gpio_eic_checker.sv]
module gpio_eic_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [gpio_eic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [gpio_eic_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [gpio_eic_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import gpio_eic_pkg::*;

  // nothing left in flight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one-deep input buffer fills when the output is stalled
  a_buffer_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready
    |=> !s_axis_tready || m_axis_tready)
    else $error("input accepted beyond buffer depth");

  // wakeup only on a sample, which returns no read data
  a_wake_sample: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[31:0] == '0)
    else $error("wakeup with read data");

  // padding stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[71:66] == '0)
    else $error("result padding not zero");

endmodule

bind gpio_edge_irq_controller gpio_eic_checker u_gpio_eic_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
